### src/lpbu_pkg.sv
package lpbu_pkg;

  localparam int SCORE_W   = 9;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int LEVEL_W   = 18;
  localparam int TOTAL_W   = 24;
  localparam int COUNT_W   = 16;
  localparam int STAGES    = 3;

  localparam logic [SCORE_W-1:0] HALF_SCORE = 9'd128;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 24'hFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;
  localparam logic [CFG_W-1:0]   FACTOR_RESET = 16'd32768;

  localparam logic signed [LEVEL_W-1:0] LEVEL_RESET = 18'sd32768;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX   = 18'sd131071;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN   = -18'sd131072;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY = 1'b0,
    CFG_GAIN  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic               activated;
    logic [TOTAL_W-1:0] total;
    logic [COUNT_W-1:0] count;
  } stat_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    stat_t                     stat;
  } result_t;

  typedef struct packed {
    logic [STAGES-1:0] stage;
    logic              done;
  } back_status_t;

endpackage

### src/lpbu_fifo.sv
module lpbu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + (AW+1)'(1);
    end else if (!push_i && pop_i) begin
      cnt_nxt = cnt_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

  assign data_o  = mem_r[rd_ptr_r];
  assign full_o  = (cnt_r == (AW+1)'(DEPTH));
  assign empty_o = (cnt_r == '0);

endmodule

### src/lpbu_front.sv
module lpbu_front #(
  parameter int HALF_WINDOW = 5,
  parameter int SUM_W       = 12,
  parameter int DIFF_W      = 13
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept_i,
  input  logic [lpbu_pkg::SCORE_W-1:0]        score_i,
  output logic signed [DIFF_W-1:0]            diff_o,
  output lpbu_pkg::stat_t                     stat_o
);

  localparam int WIN_LEN = 2 * HALF_WINDOW;
  localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(HALF_WINDOW * 128);

  logic [lpbu_pkg::SCORE_W-1:0] win_r [WIN_LEN];
  logic [SUM_W-1:0]             recent_r, recent_nxt;
  logic [SUM_W-1:0]             older_r, older_nxt;
  lpbu_pkg::stat_t              stat_r, stat_nxt;
  logic [lpbu_pkg::TOTAL_W:0]   total_sum;
  logic [lpbu_pkg::SCORE_W-1:0] moving;
  logic [lpbu_pkg::SCORE_W-1:0] oldest;

  assign moving = win_r[HALF_WINDOW-1];
  assign oldest = win_r[WIN_LEN-1];

  always_comb begin
    recent_nxt = recent_r + SUM_W'(score_i) - SUM_W'(moving);
    older_nxt  = older_r + SUM_W'(moving) - SUM_W'(oldest);
    total_sum  = {1'b0, stat_r.total} + (lpbu_pkg::TOTAL_W+1)'(score_i);
    stat_nxt.activated = stat_r.activated || (score_i >= lpbu_pkg::HALF_SCORE);
    stat_nxt.total = total_sum[lpbu_pkg::TOTAL_W] ? lpbu_pkg::TOTAL_MAX
                                                  : total_sum[lpbu_pkg::TOTAL_W-1:0];
    stat_nxt.count = (stat_r.count == lpbu_pkg::COUNT_MAX) ? stat_r.count
                                                           : stat_r.count + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        win_r[i] <= lpbu_pkg::HALF_SCORE;
      end
      recent_r <= SUM_RESET;
      older_r  <= SUM_RESET;
      stat_r   <= '0;
    end else if (accept_i) begin
      win_r[0] <= score_i;
      for (int i = 1; i < WIN_LEN; i++) begin
        win_r[i] <= win_r[i-1];
      end
      recent_r <= recent_nxt;
      older_r  <= older_nxt;
      stat_r   <= stat_nxt;
    end
  end

  assign diff_o = $signed({1'b0, recent_nxt}) - $signed({1'b0, older_nxt});
  assign stat_o = stat_nxt;

endmodule

### src/lpbu_back.sv
module lpbu_back #(
  parameter int HALF_WINDOW = 5,
  parameter int DIFF_W      = 13,
  parameter int DS_W        = 19
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [DS_W-1:0]                     decay_scaled_i,
  input  logic [lpbu_pkg::CFG_W-1:0]          gain_i,
  input  logic                                q_empty_i,
  input  logic signed [DIFF_W-1:0]            q_diff_i,
  input  lpbu_pkg::stat_t                     q_stat_i,
  output logic                                q_pop_o,
  input  logic                                o_full_i,
  output logic                                o_push_o,
  output lpbu_pkg::result_t                   o_data_o,
  output lpbu_pkg::back_status_t              status_o
);

  localparam int P1_W  = DS_W + lpbu_pkg::LEVEL_W + 1;
  localparam int P2_W  = lpbu_pkg::CFG_W + 1 + DIFF_W;
  localparam int ACC_W = DS_W + DIFF_W + 26;
  localparam int A_W   = ACC_W - 16;
  localparam int L     = $clog2(HALF_WINDOW);
  localparam int N     = lpbu_pkg::LEVEL_W + L;
  localparam int K     = N + L;
  localparam longint unsigned RECIP64 =
    ((64'd1 << K) + longint'(HALF_WINDOW) - 64'd1) / longint'(HALF_WINDOW);
  localparam logic [N:0] RECIP = RECIP64[N:0];
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(HALF_WINDOW * 32768);
  localparam logic signed [A_W-1:0]   LIM = A_W'(HALF_WINDOW * 131072);

  logic [lpbu_pkg::STAGES-1:0]       v_r, v_nxt;
  logic signed [lpbu_pkg::LEVEL_W-1:0] level_r;
  logic signed [P1_W-1:0]            p1_r;
  logic signed [P2_W-1:0]            p2_r;
  logic [N-1:0]                      aoff_r;
  logic                              hi2_r, lo2_r, hi3_r, lo3_r;
  logic [2*N:0]                      prod_r;
  lpbu_pkg::stat_t                   stat1_r, stat2_r, stat3_r;

  logic                              start;
  logic signed [ACC_W-1:0]           acc;
  logic signed [A_W-1:0]             a_val;
  logic signed [A_W-1:0]             a_off;
  logic [lpbu_pkg::LEVEL_W-1:0]      q_val;
  logic signed [lpbu_pkg::LEVEL_W-1:0] level_fin;

  assign start = !q_empty_i && (v_r == '0) && !o_full_i;

  always_comb begin
    v_nxt = {v_r[lpbu_pkg::STAGES-2:0], start};
    acc   = ACC_W'(p1_r) + (ACC_W'(p2_r) <<< 8) + RND;
    a_val = acc[ACC_W-1:16];
    a_off = a_val + LIM;
    q_val = prod_r[K+lpbu_pkg::LEVEL_W-1:K];
    if (hi3_r) begin
      level_fin = lpbu_pkg::LEVEL_MAX;
    end else if (lo3_r) begin
      level_fin = lpbu_pkg::LEVEL_MIN;
    end else begin
      level_fin = $signed({~q_val[lpbu_pkg::LEVEL_W-1], q_val[lpbu_pkg::LEVEL_W-2:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      level_r <= lpbu_pkg::LEVEL_RESET;
    end else begin
      v_r <= v_nxt;
      if (v_r[lpbu_pkg::STAGES-1]) begin
        level_r <= level_fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p1_r    <= $signed({1'b0, decay_scaled_i}) * level_r;
      p2_r    <= $signed({1'b0, gain_i}) * q_diff_i;
      stat1_r <= q_stat_i;
    end
    hi2_r   <= (a_val >= LIM);
    lo2_r   <= (a_val < -LIM);
    aoff_r  <= a_off[N-1:0];
    stat2_r <= stat1_r;
    prod_r  <= aoff_r * RECIP;
    hi3_r   <= hi2_r;
    lo3_r   <= lo2_r;
    stat3_r <= stat2_r;
  end

  assign q_pop_o         = start;
  assign o_push_o        = v_r[lpbu_pkg::STAGES-1];
  assign o_data_o.level  = level_fin;
  assign o_data_o.stat   = stat3_r;
  assign status_o.stage  = v_r;
  assign status_o.done   = v_r[lpbu_pkg::STAGES-1];

endmodule

### src/learning_progress_bandit_update_unit.sv
// Learning-progress bandit update unit.
// Input channel: drive in_score and raise push; the item is taken at a clock
// edge where push is high and full is low.
// Result channel: while empty is low, the oldest result sits on out_bandit_level,
// out_activated, out_score_total and out_play_count; raise pop to take it.
// Configuration: cfg_we with cfg_index 0 writes the decay factor, index 1 the
// gain factor, both from cfg_wdata, taking effect on the next item.
// Throughput: the front end takes one item per cycle into a small queue
// while that queue is not full; the level update takes a new item only once
// the previous one has left its pipeline, a limit set by the level recurrence
// loop through its two multiply stages and its saturation step.
// Reset: the score window returns to all 0.5, the level to 0.5, counters and
// the activated flag to zero, both factors to 0.5, and both queues drain.
// When the receiver holds off, results collect in the output queue, the
// update stops, the middle queue fills, and full rises to hold off the sender.
module learning_progress_bandit_update_unit #(
  parameter int HALF_WINDOW = 5,
  parameter int MID_DEPTH   = 4,
  parameter int OUT_DEPTH   = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic [lpbu_pkg::SCORE_W-1:0]        in_score,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [lpbu_pkg::LEVEL_W-1:0] out_bandit_level,
  output logic                                out_activated,
  output logic [lpbu_pkg::TOTAL_W-1:0]        out_score_total,
  output logic [lpbu_pkg::COUNT_W-1:0]        out_play_count,
  input  logic                                cfg_we,
  input  logic [lpbu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lpbu_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int SUM_W  = $clog2(HALF_WINDOW * 511 + 1);
  localparam int DIFF_W = SUM_W + 1;
  localparam int DS_W   = $clog2(65535 * HALF_WINDOW + 1);
  localparam int STAT_W = $bits(lpbu_pkg::stat_t);
  localparam int MID_W  = DIFF_W + STAT_W;
  localparam int RES_W  = $bits(lpbu_pkg::result_t);

  logic [DS_W-1:0]              decay_scaled_r;
  logic [lpbu_pkg::CFG_W-1:0]   gain_r;

  logic                         accept;
  logic signed [DIFF_W-1:0]     f_diff;
  lpbu_pkg::stat_t              f_stat;
  logic [MID_W-1:0]             mid_wdata, mid_rdata;
  logic                         mid_full, mid_empty, mid_pop;
  logic                         o_push, o_full;
  lpbu_pkg::result_t            o_wdata, o_rdata;
  logic [RES_W-1:0]             o_rvec;
  lpbu_pkg::back_status_t       bst;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_scaled_r <= DS_W'(32768 * HALF_WINDOW);
      gain_r         <= lpbu_pkg::FACTOR_RESET;
    end else if (cfg_we) begin
      if (cfg_index == lpbu_pkg::CFG_DECAY) begin
        decay_scaled_r <= DS_W'(32'(cfg_wdata) * HALF_WINDOW);
      end else if (cfg_index == lpbu_pkg::CFG_GAIN) begin
        gain_r <= cfg_wdata;
      end
    end
  end

  assign accept    = push && !mid_full;
  assign full      = mid_full;
  assign mid_wdata = {f_diff, f_stat};

  lpbu_front #(
    .HALF_WINDOW (HALF_WINDOW),
    .SUM_W       (SUM_W),
    .DIFF_W      (DIFF_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (accept),
    .score_i  (in_score),
    .diff_o   (f_diff),
    .stat_o   (f_stat)
  );

  lpbu_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (accept),
    .data_i  (mid_wdata),
    .pop_i   (mid_pop),
    .data_o  (mid_rdata),
    .full_o  (mid_full),
    .empty_o (mid_empty)
  );

  lpbu_back #(
    .HALF_WINDOW (HALF_WINDOW),
    .DIFF_W      (DIFF_W),
    .DS_W        (DS_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .decay_scaled_i (decay_scaled_r),
    .gain_i         (gain_r),
    .q_empty_i      (mid_empty),
    .q_diff_i       ($signed(mid_rdata[MID_W-1 -: DIFF_W])),
    .q_stat_i       (lpbu_pkg::stat_t'(mid_rdata[STAT_W-1:0])),
    .q_pop_o        (mid_pop),
    .o_full_i       (o_full),
    .o_push_o       (o_push),
    .o_data_o       (o_wdata),
    .status_o       (bst)
  );

  lpbu_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (o_push),
    .data_i  (o_wdata),
    .pop_i   (pop && !empty),
    .data_o  (o_rvec),
    .full_o  (o_full),
    .empty_o (empty)
  );

  assign o_rdata          = lpbu_pkg::result_t'(o_rvec);
  assign out_bandit_level = o_rdata.level;
  assign out_activated    = o_rdata.stat.activated;
  assign out_score_total  = o_rdata.stat.total;
  assign out_play_count   = o_rdata.stat.count;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bst.stage))
    else $error("level update holds more than one item");

  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    bst.done |-> !o_full)
    else $error("result written into a full output queue");

  a_mid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !mid_empty)
    else $error("accepted item missing from middle queue");

endmodule
